// ----- hdl/cbyp_pkg.sv -----
// ----------------------------------------------------------------------------
// cbyp_pkg
// shared widths, constants, types and helpers of the camera basis block
// ----------------------------------------------------------------------------
`default_nettype none

package cbyp_pkg;

  // field widths
  localparam int ANG_W    = 16;
  localparam int PC_W     = 15;
  localparam int EFF_W    = 17;
  localparam int OUT_W    = 16;
  localparam int MARGIN_W = 14;

  localparam logic [MARGIN_W-1:0] MARGIN_RST  = 14'd819;
  localparam logic [MARGIN_W-1:0] HALF_PI_Q13 = 14'd12868;

  // sine and cosine unit
  localparam int WA_W         = 25;
  localparam int XY_W         = 34;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

  localparam logic signed [WA_W-1:0] PI_W      = 25'sd3294199;
  localparam logic signed [WA_W-1:0] TWO_PI_W  = 25'sd6588397;
  localparam logic signed [WA_W-1:0] HALF_PI_W = 25'sd1647099;
  localparam logic signed [XY_W-1:0] GAIN_Q30  = 34'sd652032874;
  localparam logic signed [XY_W-1:0] ROUND_Q16 = 34'sd32768;

  localparam logic signed [WA_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    25'sd823550, 25'sd486170, 25'sd256879, 25'sd130396,
    25'sd65451,  25'sd32757,  25'sd16383,  25'sd8192,
    25'sd4096,   25'sd2048,   25'sd1024,   25'sd512,
    25'sd256,    25'sd128,    25'sd64,     25'sd32
  };

  // normaliser
  localparam int VEC_W       = 31;
  localparam int MAG_W       = 30;
  localparam int SQ_W        = 64;
  localparam int LEN_W       = 32;
  localparam int NUM_W       = 45;
  localparam int Q_W         = 15;
  localparam int ISQRT_STEPS = 32;
  localparam int DIV_STEPS   = 15;
  localparam int NORM_LAT    = ISQRT_STEPS + DIV_STEPS + 4;

  // whole back end, from the pop to the result registers
  localparam int PIPE_LAT = CORDIC_LAT + 1 + NORM_LAT + 1 + NORM_LAT;

  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [OUT_W-1:0] ONE_Q14 = 16'sd16384;

  typedef logic signed [VEC_W-1:0] comp_t;
  typedef logic signed [OUT_W-1:0] unit_t;

  // one classified beat, as the front hands it to the back
  typedef struct packed {
    logic signed [ANG_W-1:0] yaw;
    logic signed [PC_W-1:0]  pc;
    logic signed [EFF_W-1:0] eff;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic unit_t sat_q14(input logic signed [XY_W-1:0] v);
    unit_t r;
    if (v > XY_W'(ONE_Q14)) begin
      r = ONE_Q14;
    end else if (v < -XY_W'(ONE_Q14)) begin
      r = -ONE_Q14;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/cbyp_fifo.sv -----
// ----------------------------------------------------------------------------
// cbyp_fifo
// short register queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module cbyp_fifo #(
  parameter int Depth = cbyp_pkg::QUEUE_DEPTH
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  cbyp_pkg::item_t      item_i,
  input  wire                  pop_i,
  output cbyp_pkg::item_t      item_o,
  output cbyp_pkg::q_stat_t    stat_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  cbyp_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// ----- hdl/cbyp_front.sv -----
// ----------------------------------------------------------------------------
// cbyp_front
// margin register, pitch clamp and effective pitch, pushes into the queue
// ----------------------------------------------------------------------------
`default_nettype none

module cbyp_front (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    start_i,
  input  wire signed [cbyp_pkg::ANG_W-1:0]       yaw_i,
  input  wire signed [cbyp_pkg::ANG_W-1:0]       pitch_i,
  input  wire signed [cbyp_pkg::ANG_W-1:0]       extra_i,
  input  wire                                    cfg_we_i,
  input  wire        [cbyp_pkg::MARGIN_W-1:0]    cfg_wdata_i,
  input  cbyp_pkg::q_stat_t                      stat_i,
  output logic                                   push_o,
  output cbyp_pkg::item_t                        item_o
);

  logic [cbyp_pkg::MARGIN_W-1:0] margin_q;
  logic [cbyp_pkg::MARGIN_W-1:0] lim;
  logic signed [cbyp_pkg::EFF_W-1:0] lim_s, pitch_s, pc_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= cbyp_pkg::MARGIN_RST;
    end else if (cfg_we_i) begin
      margin_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    // a margin beyond half pi pins the limit at zero
    lim     = (margin_q > cbyp_pkg::HALF_PI_Q13) ? '0 : cbyp_pkg::HALF_PI_Q13 - margin_q;
    lim_s   = $signed({3'b000, lim});
    pitch_s = cbyp_pkg::EFF_W'(pitch_i);
    priority if (pitch_s < -lim_s) begin
      pc_s = -lim_s;
    end else if (pitch_s > lim_s) begin
      pc_s = lim_s;
    end else begin
      pc_s = pitch_s;
    end
  end

  assign push_o      = start_i && !stat_i.full;
  assign item_o.yaw  = yaw_i;
  assign item_o.pc   = pc_s[cbyp_pkg::PC_W-1:0];
  assign item_o.eff  = pc_s + cbyp_pkg::EFF_W'(extra_i);

endmodule

`default_nettype wire

// ----- hdl/cbyp_cordic.sv -----
// ----------------------------------------------------------------------------
// cbyp_cordic
// pipelined rotation cordic, sine and cosine in q1.14 of a q3.13 angle
// ----------------------------------------------------------------------------
`default_nettype none

module cbyp_cordic (
  input  wire                                clk_i,
  input  wire signed [cbyp_pkg::EFF_W-1:0]   ang_i,
  output cbyp_pkg::unit_t                    sin_o,
  output cbyp_pkg::unit_t                    cos_o
);

  localparam int N = cbyp_pkg::CORDIC_STEPS;

  logic signed [cbyp_pkg::XY_W-1:0] x_q [N+1];
  logic signed [cbyp_pkg::XY_W-1:0] y_q [N+1];
  logic signed [cbyp_pkg::WA_W-1:0] a_q [N+1];
  logic                             ng_q [N+1];

  logic signed [cbyp_pkg::WA_W-1:0] aw, af, am;
  logic                             neg;

  // widen to 2^-20 rad, fold once, then mirror into plus or minus half pi
  always_comb begin
    aw  = $signed({ang_i[cbyp_pkg::EFF_W-1], ang_i, 7'b0000000});
    af  = aw;
    neg = 1'b0;
    priority if (aw > cbyp_pkg::PI_W) begin
      af = aw - cbyp_pkg::TWO_PI_W;
    end else if (aw < -cbyp_pkg::PI_W) begin
      af = aw + cbyp_pkg::TWO_PI_W;
    end else begin
      af = aw;
    end
    priority if (af > cbyp_pkg::HALF_PI_W) begin
      am  = cbyp_pkg::PI_W - af;
      neg = 1'b1;
    end else if (af < -cbyp_pkg::HALF_PI_W) begin
      am  = -cbyp_pkg::PI_W - af;
      neg = 1'b1;
    end else begin
      am  = af;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]  <= cbyp_pkg::GAIN_Q30;
    y_q[0]  <= '0;
    a_q[0]  <= am;
    ng_q[0] <= neg;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [cbyp_pkg::XY_W-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      ng_q[i+1] <= ng_q[i];
      if (a_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        a_q[i+1] <= a_q[i] - cbyp_pkg::ATAN_TAB[i];
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        a_q[i+1] <= a_q[i] + cbyp_pkg::ATAN_TAB[i];
      end
    end
  end

  logic signed [cbyp_pkg::XY_W-1:0] ys, xs;
  cbyp_pkg::unit_t                  cs;

  always_comb begin
    ys = (y_q[N] + cbyp_pkg::ROUND_Q16) >>> 16;
    xs = (x_q[N] + cbyp_pkg::ROUND_Q16) >>> 16;
    cs = cbyp_pkg::sat_q14(xs);
  end

  always_ff @(posedge clk_i) begin
    sin_o <= cbyp_pkg::sat_q14(ys);
    cos_o <= ng_q[N] ? -cs : cs;
  end

endmodule

`default_nettype wire

// ----- hdl/cbyp_norm.sv -----
// ----------------------------------------------------------------------------
// cbyp_norm
// pipelined normaliser: squares, bitwise square root, restoring division
// ----------------------------------------------------------------------------
`default_nettype none

module cbyp_norm (
  input  wire              clk_i,
  input  cbyp_pkg::comp_t  v_i [3],
  output cbyp_pkg::unit_t  n_o [3]
);

  localparam int MW = cbyp_pkg::MAG_W;
  localparam int SW = cbyp_pkg::SQ_W;
  localparam int LW = cbyp_pkg::LEN_W;
  localparam int NW = cbyp_pkg::NUM_W;
  localparam int QW = cbyp_pkg::Q_W;
  localparam int IS = cbyp_pkg::ISQRT_STEPS;
  localparam int DS = cbyp_pkg::DIV_STEPS;

  // magnitudes and squares
  logic [MW-1:0]     mag_a_q [3];
  logic [2*MW-1:0]   sq_a_q  [3];
  logic [2:0]        neg_a_q;
  logic [cbyp_pkg::VEC_W-1:0] abs_v [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      abs_v[k] = v_i[k][cbyp_pkg::VEC_W-1] ? -v_i[k] : v_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      neg_a_q[k] <= v_i[k][cbyp_pkg::VEC_W-1];
      mag_a_q[k] <= abs_v[k][MW-1:0];
      sq_a_q[k]  <= abs_v[k][MW-1:0] * abs_v[k][MW-1:0];
    end
  end

  // square root pipe, entry 0 holds the summed squares
  logic [SW-1:0] rv_q [IS+1];
  logic [SW-1:0] rr_q [IS+1];
  logic [MW-1:0] mg_q [IS+1][3];
  logic [2:0]    ng_q [IS+1];

  always_ff @(posedge clk_i) begin
    rv_q[0] <= SW'(sq_a_q[0]) + SW'(sq_a_q[1]) + SW'(sq_a_q[2]);
    rr_q[0] <= '0;
    mg_q[0] <= mag_a_q;
    ng_q[0] <= neg_a_q;
  end

  for (genvar i = 0; i < IS; i++) begin : g_sqrt
    localparam logic [SW-1:0] Bit = SW'(1) << (62 - 2 * i);
    logic [SW-1:0] trial;
    assign trial = rr_q[i] + Bit;
    always_ff @(posedge clk_i) begin
      mg_q[i+1] <= mg_q[i];
      ng_q[i+1] <= ng_q[i];
      if (rv_q[i] >= trial) begin
        rv_q[i+1] <= rv_q[i] - trial;
        rr_q[i+1] <= (rr_q[i] >> 1) + Bit;
      end else begin
        rv_q[i+1] <= rv_q[i];
        rr_q[i+1] <= rr_q[i] >> 1;
      end
    end
  end

  // rounded numerators, then one quotient bit a stage
  logic [LW-1:0] len;
  logic [NW-1:0] num_c [3];

  assign len = rr_q[IS][LW-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_c[k] = {1'b0, mg_q[IS][k], 14'b0} + NW'(len >> 1);
    end
  end

  logic [LW-1:0] rem_q [DS+1][3];
  logic [QW-1:0] quo_q [DS+1][3];
  logic [NW-1:0] num_q [DS+1][3];
  logic [LW-1:0] len_q [DS+1];
  logic [2:0]    sg_q  [DS+1];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      num_q[0][k] <= num_c[k];
      rem_q[0][k] <= LW'(num_c[k] >> DS);
      quo_q[0][k] <= '0;
    end
    len_q[0] <= len;
    sg_q[0]  <= ng_q[IS];
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    localparam int Bk = DS - 1 - j;
    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [LW:0] trial;
      assign trial = {rem_q[j][k], num_q[j][k][Bk]};
      always_ff @(posedge clk_i) begin
        num_q[j+1][k] <= num_q[j][k];
        if (trial >= {1'b0, len_q[j]}) begin
          rem_q[j+1][k] <= LW'(trial - {1'b0, len_q[j]});
          quo_q[j+1][k] <= {quo_q[j][k][QW-2:0], 1'b1};
        end else begin
          rem_q[j+1][k] <= trial[LW-1:0];
          quo_q[j+1][k] <= {quo_q[j][k][QW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      len_q[j+1] <= len_q[j];
      sg_q[j+1]  <= sg_q[j];
    end
  end

  cbyp_pkg::unit_t q_s [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q_s[k] = $signed({1'b0, quo_q[DS][k]});
    end
  end

  // a zero length vector comes out as all zeros
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (len_q[DS] == '0) begin
        n_o[k] <= '0;
      end else begin
        n_o[k] <= sg_q[DS][k] ? -q_s[k] : q_s[k];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/cbyp_back.sv -----
// ----------------------------------------------------------------------------
// cbyp_back
// pops the queue on every cycle that it is not empty and runs the trig, normalise and cross pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module cbyp_back (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  cbyp_pkg::q_stat_t                stat_i,
  input  cbyp_pkg::item_t                  item_i,
  output logic                             pop_o,
  output logic                             done_o,
  output logic signed [cbyp_pkg::PC_W-1:0] pc_o,
  output cbyp_pkg::unit_t                  fwd_o [3],
  output cbyp_pkg::unit_t                  rgt_o [3],
  output cbyp_pkg::unit_t                  up_o  [3]
);

  localparam int L  = cbyp_pkg::PIPE_LAT;
  localparam int FD = cbyp_pkg::NORM_LAT + 1;

  assign pop_o = !stat_i.empty;

  // valid and clamped pitch follow the data down the pipe
  logic [L-1:0]                     vld_q;
  logic signed [cbyp_pkg::PC_W-1:0] pc_q [L];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[L-2:0], pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q[0] <= item_i.pc;
    for (int s = 1; s < L; s++) begin
      pc_q[s] <= pc_q[s-1];
    end
  end

  cbyp_pkg::unit_t sy, cy, sp, cp;

  cbyp_cordic u_yaw (
    .clk_i (clk_i),
    .ang_i ({item_i.yaw[cbyp_pkg::ANG_W-1], item_i.yaw}),
    .sin_o (sy),
    .cos_o (cy)
  );

  cbyp_cordic u_pitch (
    .clk_i (clk_i),
    .ang_i (item_i.eff),
    .sin_o (sp),
    .cos_o (cp)
  );

  cbyp_pkg::comp_t fw_q [3];
  cbyp_pkg::comp_t rt_q [3];

  always_ff @(posedge clk_i) begin
    fw_q[0] <= cbyp_pkg::VEC_W'(cp * sy);
    fw_q[1] <= cbyp_pkg::VEC_W'(sp) <<< 14;
    fw_q[2] <= cbyp_pkg::VEC_W'(cp * cy);
    rt_q[0] <= cbyp_pkg::VEC_W'(cy) <<< 14;
    rt_q[1] <= '0;
    rt_q[2] <= -(cbyp_pkg::VEC_W'(sy) <<< 14);
  end

  cbyp_pkg::unit_t fn [3];
  cbyp_pkg::unit_t rn [3];

  cbyp_norm u_fwd (.clk_i(clk_i), .v_i(fw_q), .n_o(fn));
  cbyp_norm u_rgt (.clk_i(clk_i), .v_i(rt_q), .n_o(rn));

  // up = right x forward, right y is always zero
  cbyp_pkg::comp_t up_q [3];

  always_ff @(posedge clk_i) begin
    up_q[0] <= -cbyp_pkg::VEC_W'(rn[2] * fn[1]);
    up_q[1] <= cbyp_pkg::VEC_W'(rn[2] * fn[0]) - cbyp_pkg::VEC_W'(rn[0] * fn[2]);
    up_q[2] <= cbyp_pkg::VEC_W'(rn[0] * fn[1]);
  end

  cbyp_norm u_up (.clk_i(clk_i), .v_i(up_q), .n_o(up_o));

  cbyp_pkg::unit_t fd_q [FD][3];
  cbyp_pkg::unit_t rd_q [FD][3];

  always_ff @(posedge clk_i) begin
    fd_q[0] <= fn;
    rd_q[0] <= rn;
    for (int s = 1; s < FD; s++) begin
      fd_q[s] <= fd_q[s-1];
      rd_q[s] <= rd_q[s-1];
    end
  end

  assign done_o = vld_q[L-1];
  assign pc_o   = pc_q[L-1];
  assign fwd_o  = fd_q[FD-1];
  assign rgt_o  = rd_q[FD-1];

endmodule

`default_nettype wire

// ----- hdl/camera_basis_from_yaw_pitch.sv -----
// ----------------------------------------------------------------------------
// camera_basis_from_yaw_pitch
// forward, right and up unit vectors from yaw and clamped pitch
// ----------------------------------------------------------------------------
// a beat is taken on any clock edge with start high and busy low, and busy
// stays low in steady use, so a new angle set can go in on every cycle. each
// beat gives exactly one result, shown for a single cycle with done_o high;
// the receiver cannot hold it off, so it must sample on that cycle. a
// taken beat passes through the queue and then through the back pipeline: an
// 18-stage sine/cosine cordic, then two 51-stage normalisers in series (32
// square root steps and 15 quotient bit steps each) with a cross product
// stage between them. pitch_margin is written through cfg_we_i/cfg_wdata_i
// and should only change while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_basis_from_yaw_pitch #(
  parameter int QueueDepth = cbyp_pkg::QUEUE_DEPTH
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  // command side
  input  wire                                     start,
  output logic                                    busy,
  input  wire signed [cbyp_pkg::ANG_W-1:0]        yaw_angle_i,
  input  wire signed [cbyp_pkg::ANG_W-1:0]        pitch_angle_i,
  input  wire signed [cbyp_pkg::ANG_W-1:0]        pitch_extra_i,
  // pitch margin register
  input  wire                                     cfg_we_i,
  input  wire        [cbyp_pkg::MARGIN_W-1:0]     cfg_wdata_i,
  // result side
  output logic                                    done_o,
  output logic signed [cbyp_pkg::PC_W-1:0]        pitch_clamped_o,
  output logic signed [cbyp_pkg::OUT_W-1:0]       fwd_x_o,
  output logic signed [cbyp_pkg::OUT_W-1:0]       fwd_y_o,
  output logic signed [cbyp_pkg::OUT_W-1:0]       fwd_z_o,
  output logic signed [cbyp_pkg::OUT_W-1:0]       rgt_x_o,
  output logic signed [cbyp_pkg::OUT_W-1:0]       rgt_y_o,
  output logic signed [cbyp_pkg::OUT_W-1:0]       rgt_z_o,
  output logic signed [cbyp_pkg::OUT_W-1:0]       up_x_o,
  output logic signed [cbyp_pkg::OUT_W-1:0]       up_y_o,
  output logic signed [cbyp_pkg::OUT_W-1:0]       up_z_o
);

  cbyp_pkg::q_stat_t stat;
  cbyp_pkg::item_t   push_item, pop_item;
  logic              push, pop;
  cbyp_pkg::unit_t   fwd [3];
  cbyp_pkg::unit_t   rgt [3];
  cbyp_pkg::unit_t   up  [3];

  // front: clamp against the margin and form the effective pitch
  cbyp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .yaw_i       (yaw_angle_i),
    .pitch_i     (pitch_angle_i),
    .extra_i     (pitch_extra_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_i      (stat),
    .push_o      (push),
    .item_o      (push_item)
  );

  // queue decouples the command side from the back pipeline
  cbyp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (stat)
  );

  // back: trig, normalise, cross product, normalise
  cbyp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .item_i (pop_item),
    .pop_o  (pop),
    .done_o (done_o),
    .pc_o   (pitch_clamped_o),
    .fwd_o  (fwd),
    .rgt_o  (rgt),
    .up_o   (up)
  );

  assign busy    = stat.full;
  assign fwd_x_o = fwd[0];
  assign fwd_y_o = fwd[1];
  assign fwd_z_o = fwd[2];
  assign rgt_x_o = rgt[0];
  assign rgt_y_o = rgt[1];
  assign rgt_z_o = rgt[2];
  assign up_x_o  = up[0];
  assign up_y_o  = up[1];
  assign up_z_o  = up[2];

endmodule

`default_nettype wire

// ----- hdl/cbyp_checker.sv -----
// ----------------------------------------------------------------------------
// cbyp_checker
// port level checks on the camera basis block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module cbyp_checker (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 start,
  input wire                                 busy,
  input wire                                 done_o,
  input wire signed [cbyp_pkg::OUT_W-1:0]    fwd_y_o,
  input wire signed [cbyp_pkg::OUT_W-1:0]    rgt_y_o,
  input wire signed [cbyp_pkg::OUT_W-1:0]    up_y_o
);

  localparam int Lat = cbyp_pkg::PIPE_LAT + 1;

  a_beat_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(Lat) done_o)
    else $error("beat taken without a result at the expected latency");

  a_done_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Lat))
    else $error("result without a matching beat");

  a_rgt_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rgt_y_o == '0)
    else $error("right vector left the horizontal plane");

  a_unit_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (fwd_y_o <= cbyp_pkg::ONE_Q14) && (fwd_y_o >= -cbyp_pkg::ONE_Q14) &&
               (up_y_o <= cbyp_pkg::ONE_Q14) && (up_y_o >= -cbyp_pkg::ONE_Q14))
    else $error("unit vector component out of range");

endmodule

bind camera_basis_from_yaw_pitch cbyp_checker u_chk (.*);

`default_nettype wire
